@@ src/ntt_pkg.sv @@
package ntt_pkg;

    localparam int Slots = 8;
    localparam int SlotIdxW = $clog2(Slots);
    localparam int IdW = 15;
    localparam int WeightW = 24;
    localparam int TrafficW = 15;
    localparam int DamageInW = 16;
    localparam int AvgW = 16;
    localparam int VisitW = 32;
    localparam int DamageW = 40;
    localparam int OpW = 3;
    localparam int DivNumW = 64;
    localparam int DivDenW = 32;
    localparam int DivCntW = $clog2(DivNumW + 1);

    localparam logic [WeightW-1:0] WeightMax = '1;
    localparam logic [TrafficW-1:0] TrafficMax = '1;
    localparam logic [VisitW-1:0] VisitMax = '1;
    localparam logic [DamageW-1:0] DamageMax = '1;
    localparam logic [WeightW-1:0] CampLimitReset = 24'd384;

    typedef enum logic [OpW-1:0] {
        OP_SET = 3'd0,
        OP_ADD_TRAFFIC = 3'd1,
        OP_DELETE = 3'd2,
        OP_GET_TRAFFIC = 3'd3,
        OP_ADD_DAMAGE = 3'd4,
        OP_GET_DAMAGE = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_SHIFT,
        ST_WRITE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic [DivNumW-1:0] num;
        logic [DivDenW-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic done;
        logic [DivNumW-1:0] quo;
    } div_rsp_t;

endpackage

@@ src/neighbour_traffic_table.sv @@
// Channel  | Dir | tdata fields (low bit up)                       | tuser
// s_axis   | in  | opcode[2:0] neighbour_id[17:3] weight_in[41:18]  | -
//          |     | damage_in[57:42], zero fill to 64 bits          |
// m_axis   | out | success[0] traffic_out[15:1] average_damage[31:16]| -
// cfg      | in  | camp_limit, written when cfg_we is high         | -
// A transaction is taken in idle; set, add traffic, delete and get traffic then scan the
// slots one per cycle. Add traffic that averages a weight, and get damage with visits, use
// the shared divider; add traffic then writes the weight in ST_WRITE.
// Delete moves later slots down one per cycle.
// Results wait in an output register, and no new transaction is taken until it is taken.
// Reset clears all slots and counters at once.
module neighbour_traffic_table
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // opcode, neighbour_id, weight_in, damage_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // success, traffic_out, average_damage
    input  logic        cfg_we,
    input  logic [23:0] cfg_wdata
);

    localparam int SW = ntt_pkg::SlotIdxW;

    ntt_pkg::state_t state_reg, state_next;
    logic [ntt_pkg::Slots-1:0] valid_reg, valid_next;
    logic [ntt_pkg::IdW-1:0] id_reg [ntt_pkg::Slots];
    logic [ntt_pkg::IdW-1:0] id_next [ntt_pkg::Slots];
    logic [ntt_pkg::WeightW-1:0] weight_reg [ntt_pkg::Slots];
    logic [ntt_pkg::WeightW-1:0] weight_next [ntt_pkg::Slots];
    logic [ntt_pkg::TrafficW-1:0] traffic_reg [ntt_pkg::Slots];
    logic [ntt_pkg::TrafficW-1:0] traffic_next [ntt_pkg::Slots];
    logic [ntt_pkg::VisitW-1:0] visit_reg, visit_next;
    logic [ntt_pkg::DamageW-1:0] damage_reg, damage_next;
    logic [ntt_pkg::WeightW-1:0] camp_reg, camp_next;

    logic [ntt_pkg::OpW-1:0] op_reg, op_next;
    logic [ntt_pkg::IdW-1:0] nid_reg, nid_next;
    logic [ntt_pkg::WeightW-1:0] win_reg, win_next;
    logic [SW-1:0] idx_reg, idx_next;
    logic [31:0] res_reg, res_next;

    ntt_pkg::div_req_t dreq;
    ntt_pkg::div_rsp_t drsp;

    logic cur_match, cur_empty, last_idx;
    logic [ntt_pkg::TrafficW-1:0] bumped;
    logic [ntt_pkg::DamageW:0] dsum;
    logic [ntt_pkg::DivNumW-1:0] wnum;
    logic [ntt_pkg::TrafficW:0] tp1;
    logic [ntt_pkg::TrafficW+ntt_pkg::WeightW-1:0] prod;

    ntt_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    assign cur_match = valid_reg[idx_reg] && (id_reg[idx_reg] == nid_reg);
    assign cur_empty = !valid_reg[idx_reg];
    assign last_idx = (idx_reg == SW'(ntt_pkg::Slots - 1));
    assign bumped = (traffic_reg[idx_reg] == ntt_pkg::TrafficMax) ? ntt_pkg::TrafficMax
                    : traffic_reg[idx_reg] + 1'b1;
    assign dsum = {1'b0, damage_reg} + (ntt_pkg::DamageW + 1)'(s_axis_tdata[57:42]);
    assign tp1 = {1'b0, bumped} + 1'b1;
    assign prod = (ntt_pkg::TrafficW + ntt_pkg::WeightW)'(bumped)
                  * (ntt_pkg::TrafficW + ntt_pkg::WeightW)'(weight_reg[idx_reg]);
    assign wnum = ntt_pkg::DivNumW'(prod) + ntt_pkg::DivNumW'(win_reg)
                  + ntt_pkg::DivNumW'(tp1[ntt_pkg::TrafficW:1]);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ntt_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    case (s_axis_tdata[2:0])
                        ntt_pkg::OP_SET, ntt_pkg::OP_ADD_TRAFFIC, ntt_pkg::OP_DELETE,
                        ntt_pkg::OP_GET_TRAFFIC: state_next = ntt_pkg::ST_SCAN;
                        ntt_pkg::OP_GET_DAMAGE: state_next = (visit_reg != '0)
                            ? ntt_pkg::ST_DIV : ntt_pkg::ST_OUT;
                        default: state_next = ntt_pkg::ST_OUT;
                    endcase
                end
            end
            ntt_pkg::ST_SCAN:
            begin
                case (op_reg)
                    ntt_pkg::OP_SET:
                        if (cur_match || cur_empty || last_idx)
                            state_next = ntt_pkg::ST_OUT;
                    ntt_pkg::OP_ADD_TRAFFIC:
                        if (cur_match)
                            state_next = (win_reg < camp_reg) ? ntt_pkg::ST_DIV
                                                               : ntt_pkg::ST_OUT;
                        else if (cur_empty || last_idx)
                            state_next = ntt_pkg::ST_OUT;
                    ntt_pkg::OP_DELETE:
                        if (cur_match)
                            state_next = ntt_pkg::ST_SHIFT;
                        else if (last_idx)
                            state_next = ntt_pkg::ST_OUT;
                    default:
                        if (cur_match || last_idx)
                            state_next = ntt_pkg::ST_OUT;
                endcase
            end
            ntt_pkg::ST_DIV:
                if (drsp.done)
                    state_next = (op_reg == ntt_pkg::OP_ADD_TRAFFIC) ? ntt_pkg::ST_WRITE
                                                                      : ntt_pkg::ST_OUT;
            ntt_pkg::ST_WRITE: state_next = ntt_pkg::ST_OUT;
            ntt_pkg::ST_SHIFT:
                if (last_idx)
                    state_next = ntt_pkg::ST_OUT;
            ntt_pkg::ST_OUT:
                if (m_axis_tready)
                    state_next = ntt_pkg::ST_IDLE;
            default: state_next = ntt_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        id_next = id_reg;
        weight_next = weight_reg;
        traffic_next = traffic_reg;
        visit_next = visit_reg;
        damage_next = damage_reg;
        camp_next = cfg_we ? cfg_wdata : camp_reg;
        op_next = op_reg;
        nid_next = nid_reg;
        win_next = win_reg;
        idx_next = idx_reg;
        res_next = res_reg;
        dreq.start = 1'b0;
        dreq.num = wnum;
        dreq.den = 32'(tp1);
        case (state_reg)
            ntt_pkg::ST_IDLE:
            begin
                op_next = s_axis_tdata[2:0];
                nid_next = s_axis_tdata[17:3];
                win_next = s_axis_tdata[41:18];
                idx_next = '0;
                res_next = '0;
                if (s_axis_tvalid)
                begin
                    case (s_axis_tdata[2:0])
                        ntt_pkg::OP_ADD_TRAFFIC:
                            if (visit_reg != ntt_pkg::VisitMax)
                                visit_next = visit_reg + 1'b1;
                        ntt_pkg::OP_ADD_DAMAGE:
                        begin
                            damage_next = dsum[ntt_pkg::DamageW] ? ntt_pkg::DamageMax
                                          : dsum[ntt_pkg::DamageW-1:0];
                            res_next[0] = 1'b1;
                        end
                        ntt_pkg::OP_GET_DAMAGE:
                        begin
                            res_next[0] = 1'b1;
                            dreq.start = (visit_reg != '0);
                            dreq.num = ntt_pkg::DivNumW'(damage_reg);
                            dreq.den = visit_reg;
                        end
                        default: ;
                    endcase
                end
            end
            ntt_pkg::ST_SCAN:
            begin
                idx_next = idx_reg + 1'b1;
                case (op_reg)
                    ntt_pkg::OP_SET:
                        if (cur_match || cur_empty)
                        begin
                            valid_next[idx_reg] = 1'b1;
                            id_next[idx_reg] = nid_reg;
                            weight_next[idx_reg] = win_reg;
                            res_next[0] = 1'b1;
                        end
                    ntt_pkg::OP_ADD_TRAFFIC:
                        if (cur_match)
                        begin
                            idx_next = idx_reg;
                            traffic_next[idx_reg] = bumped;
                            res_next[0] = 1'b1;
                        end
                        else if (cur_empty)
                        begin
                            traffic_next[idx_reg] = bumped;
                            valid_next[idx_reg] = 1'b1;
                            id_next[idx_reg] = nid_reg;
                            weight_next[idx_reg] = win_reg;
                            res_next[0] = 1'b1;
                        end
                    ntt_pkg::OP_DELETE:
                        if (cur_match)
                        begin
                            idx_next = idx_reg;
                            res_next[0] = 1'b1;
                        end
                    ntt_pkg::OP_GET_TRAFFIC:
                        if (cur_match)
                        begin
                            res_next[0] = 1'b1;
                            res_next[15:1] = traffic_reg[idx_reg];
                        end
                    default: ;
                endcase
            end
            ntt_pkg::ST_DIV:
            begin
                if (drsp.done && op_reg == ntt_pkg::OP_GET_DAMAGE)
                    res_next[31:16] = (drsp.quo[63:16] != '0) ? 16'hFFFF : drsp.quo[15:0];
            end
            ntt_pkg::ST_WRITE:
                weight_next[idx_reg] = drsp.quo[ntt_pkg::WeightW-1:0];
            ntt_pkg::ST_SHIFT:
            begin
                if (last_idx)
                begin
                    valid_next[idx_reg] = 1'b0;
                    id_next[idx_reg] = '0;
                    weight_next[idx_reg] = ntt_pkg::WeightMax;
                    traffic_next[idx_reg] = '0;
                end
                else
                begin
                    valid_next[idx_reg] = valid_reg[idx_reg + 1'b1];
                    id_next[idx_reg] = id_reg[idx_reg + 1'b1];
                    weight_next[idx_reg] = weight_reg[idx_reg + 1'b1];
                    traffic_next[idx_reg] = traffic_reg[idx_reg + 1'b1];
                    idx_next = idx_reg + 1'b1;
                end
            end
            default: ;
        endcase
        // The running-mean division is launched as the scan leaves a matching slot.
        if (state_reg == ntt_pkg::ST_SCAN && state_next == ntt_pkg::ST_DIV)
            dreq.start = 1'b1;
    end

    assign s_axis_tready = (state_reg == ntt_pkg::ST_IDLE);
    assign m_axis_tvalid = (state_reg == ntt_pkg::ST_OUT);
    assign m_axis_tdata = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ntt_pkg::ST_IDLE;
            valid_reg <= '0;
            visit_reg <= '0;
            damage_reg <= '0;
            camp_reg <= ntt_pkg::CampLimitReset;
            for (int i = 0; i < ntt_pkg::Slots; i++)
            begin
                id_reg[i] <= '0;
                weight_reg[i] <= ntt_pkg::WeightMax;
                traffic_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            visit_reg <= visit_next;
            damage_reg <= damage_next;
            camp_reg <= camp_next;
            id_reg <= id_next;
            weight_reg <= weight_next;
            traffic_reg <= traffic_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        nid_reg <= nid_next;
        win_reg <= win_next;
        idx_reg <= idx_next;
        res_reg <= res_next;
    end

endmodule

@@ src/ntt_divider.sv @@
module ntt_divider
(
    input  logic             clk,
    input  logic             rst_n,
    input  ntt_pkg::div_req_t req,
    output ntt_pkg::div_rsp_t rsp
);

    logic [ntt_pkg::DivNumW-1:0] quo_reg, quo_next;
    logic [ntt_pkg::DivDenW:0] rem_reg, rem_next;
    logic [ntt_pkg::DivDenW-1:0] den_reg, den_next;
    logic [ntt_pkg::DivCntW-1:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic done_reg, done_next;
    logic [ntt_pkg::DivDenW:0] trial;

    // One quotient bit per cycle, restoring division.
    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {rem_reg[ntt_pkg::DivDenW-1:0], quo_reg[ntt_pkg::DivNumW-1]};
        if (req.start)
        begin
            quo_next = req.num;
            rem_next = '0;
            den_next = req.den;
            cnt_next = ntt_pkg::DivCntW'(ntt_pkg::DivNumW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                quo_next = {quo_reg[ntt_pkg::DivNumW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[ntt_pkg::DivNumW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == ntt_pkg::DivCntW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo = quo_reg;

endmodule

@@ src/ntt_checker.sv @@
module ntt_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    // The block never takes a transaction while a result is pending.
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while result pending");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed under stall");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("ready right after accept");

    a_fail: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[31:1] == '0)
        else $error("failed result carries data");

endmodule

bind neighbour_traffic_table ntt_checker u_ntt_checker
(
    .clk(clk),
    .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
